/* sv/s88fb_pkg.sv */
// Shared constants and types for the feedback shift-register bus reader.
`default_nettype none

package s88fb_pkg;

	// Default chain length limit for the contact image store.
	localparam int MAX_MODULES_DEF = 32;

	// Configuration register widths and layout.
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 15;
	localparam int COUNT_W       = 6;
	localparam int BASE_W        = 15;
	localparam int ADDR_W        = 16;
	localparam int TICK_W        = 10;
	localparam int BIT_W         = 3;
	localparam int MODULE_BITS   = 8;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_ENABLE       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MODULE_COUNT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_BASE = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [COUNT_W-1:0] MODULE_COUNT_RST = 6'd1;

	// Tick schedule of one bus scan.
	localparam logic [TICK_W-1:0] TICK_LOAD_ON    = 10'd3;
	localparam logic [TICK_W-1:0] TICK_CLOCK_ON   = 10'd4;
	localparam logic [TICK_W-1:0] TICK_FIRST_READ = 10'd5;
	localparam logic [TICK_W-1:0] TICK_RESET_ON   = 10'd9;
	localparam logic [TICK_W-1:0] TICK_RESET_OFF  = 10'd10;
	localparam logic [TICK_W-1:0] TICK_LOAD_OFF   = 10'd11;
	localparam logic [TICK_W-1:0] TICK_SHIFT      = 10'd12;

	// Contact image value after enable or reset: all contacts high.
	localparam logic [MODULE_BITS-1:0] IMAGE_RST = 8'hFF;

	// Levels driven on the three bus control lines.
	typedef struct packed {
		logic load;
		logic clock;
		logic reset;
	} bus_lines_t;

endpackage

`default_nettype wire

/* sv/s88_feedback_bus_reader.sv */
// Top level of the feedback shift-register bus reader (bus master sequencer).
// The result transaction for a tick shows on the output in the cycle after the tick is
// accepted; one tick is accepted per clock while the output does not stall, set by the single output register.
// The input stalls only while a finished result waits and the output side stalls.
// Reset (arst_n low) clears the scan counters, the line levels and the output valid, loads the
// configuration defaults (disabled, one module, base zero) and sets the contact image to all ones.
`default_nettype none

module s88_feedback_bus_reader #(
	parameter int MAX_MODULES = s88fb_pkg::MAX_MODULES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	// Configuration write port.
	input  wire logic                                cfg_write,
	input  wire logic [s88fb_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [s88fb_pkg::CFG_DATA_W-1:0]    cfg_data,

	// Tick channel: one transaction per paced bus tick.
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                data_in,

	// Result channel: one transaction per accepted tick.
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     load_level,
	output logic                                     clock_level,
	output logic                                     reset_level,
	output logic                                     change_valid,
	output logic [s88fb_pkg::ADDR_W-1:0]             change_address,
	output logic                                     change_level
);

	// The image index needs enough bits to address every module of the store.
	localparam int IDX_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
	// Counts are compared one bit wider so that a limit of 64 still fits.
	localparam int CMP_W = s88fb_pkg::COUNT_W + 1;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_MODULES);

	// Configuration registers.
	logic                                  enable_q;
	logic [s88fb_pkg::COUNT_W-1:0]         module_count_q;
	logic [s88fb_pkg::BASE_W-1:0]          address_base_q;

	// Scan state.
	logic [s88fb_pkg::TICK_W-1:0]          tick_q;
	logic [s88fb_pkg::COUNT_W-1:0]         module_index_q;
	logic [s88fb_pkg::BIT_W-1:0]           bit_index_q;
	s88fb_pkg::bus_lines_t                 lines_q;
	logic [s88fb_pkg::MODULE_BITS-1:0]     image_q [MAX_MODULES];

	// Output register.
	logic                                  out_valid_q;
	s88fb_pkg::bus_lines_t                 out_lines_q;
	logic                                  change_valid_q;
	logic [s88fb_pkg::ADDR_W-1:0]          change_address_q;
	logic                                  change_level_q;

	// Next-state logic for one tick.
	logic                                  accept;
	logic                                  enable_write;
	logic [CMP_W-1:0]                      eff_count;
	logic                                  read_tick;
	logic                                  in_range;
	logic [IDX_W-1:0]                      image_idx;
	logic                                  old_bit;
	logic                                  changed;
	logic [s88fb_pkg::ADDR_W-1:0]          change_addr;
	logic [s88fb_pkg::BIT_W-1:0]           bit_index_inc;
	logic [s88fb_pkg::COUNT_W-1:0]         module_index_inc;
	logic [s88fb_pkg::TICK_W-1:0]          tick_inc;
	s88fb_pkg::bus_lines_t                 lines_step;
	logic                                  restart;
	s88fb_pkg::bus_lines_t                 lines_next;

	// A new tick enters whenever the output register is empty or is being emptied.
	assign in_stall     = out_valid_q & out_stall;
	assign accept       = in_valid & ~in_stall;
	assign enable_write = cfg_write && (cfg_index == s88fb_pkg::REG_ENABLE) && cfg_data[0];

	// Chain length, saturated to the size of the image store.
	assign eff_count = ({1'b0, module_count_q} > MAX_CMP) ? MAX_CMP : {1'b0, module_count_q};

	// Ticks that drop the clock and sample the data line: the first read, then every odd
	// tick of the shift phase.
	assign read_tick = (tick_q == s88fb_pkg::TICK_FIRST_READ) ||
		((tick_q >= s88fb_pkg::TICK_SHIFT) && tick_q[0]);

	// A module index at or past the chain length (after a count change) compares nothing.
	assign in_range  = ({1'b0, module_index_q} < eff_count) && ({1'b0, module_index_q} < MAX_CMP);
	assign image_idx = module_index_q[IDX_W-1:0];
	assign old_bit   = image_q[image_idx][bit_index_q];
	assign changed   = read_tick && in_range && (old_bit != data_in);

	// Contact address: base plus module times eight plus bit.
	assign change_addr = s88fb_pkg::ADDR_W'(address_base_q) +
		s88fb_pkg::ADDR_W'({module_index_q, bit_index_q});

	assign bit_index_inc    = bit_index_q + 1'b1;
	assign module_index_inc = (bit_index_q == '1) ? module_index_q + 1'b1 : module_index_q;
	assign tick_inc         = tick_q + 1'b1;

	// Line levels driven by this tick's schedule entry.
	always_comb begin
		lines_step = lines_q;
		if (tick_q == s88fb_pkg::TICK_LOAD_ON) begin
			lines_step.load = 1'b1;
		end else if (tick_q == s88fb_pkg::TICK_CLOCK_ON) begin
			lines_step.clock = 1'b1;
		end else if (tick_q == s88fb_pkg::TICK_RESET_ON) begin
			lines_step.reset = 1'b1;
		end else if (tick_q == s88fb_pkg::TICK_RESET_OFF) begin
			lines_step.reset = 1'b0;
		end else if (tick_q == s88fb_pkg::TICK_LOAD_OFF) begin
			lines_step.load = 1'b0;
		end else if (read_tick) begin
			lines_step.clock = 1'b0;
		end else if (tick_q >= s88fb_pkg::TICK_SHIFT) begin
			lines_step.clock = 1'b1;
		end
	end

	// The scan restarts at the end of the tick once every module has been read; the lines
	// of that tick already show low.
	assign restart    = {1'b0, (read_tick ? module_index_inc : module_index_q)} >= eff_count;
	assign lines_next = restart ? '0 : lines_step;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b0;
			module_count_q <= s88fb_pkg::MODULE_COUNT_RST;
			address_base_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				s88fb_pkg::REG_ENABLE:       enable_q       <= cfg_data[0];
				s88fb_pkg::REG_MODULE_COUNT: module_count_q <= cfg_data[s88fb_pkg::COUNT_W-1:0];
				s88fb_pkg::REG_ADDRESS_BASE: address_base_q <= cfg_data[s88fb_pkg::BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// Scan counters and line levels. A disabled block holds all of them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q         <= '0;
			module_index_q <= '0;
			bit_index_q    <= '0;
			lines_q        <= '0;
		end else if (enable_write) begin
			tick_q         <= '0;
			module_index_q <= '0;
			bit_index_q    <= '0;
			lines_q        <= '0;
		end else if (accept && enable_q) begin
			lines_q <= lines_next;
			if (restart) begin
				tick_q         <= '0;
				module_index_q <= '0;
				bit_index_q    <= '0;
			end else begin
				tick_q <= tick_inc;
				if (read_tick) begin
					bit_index_q    <= bit_index_inc;
					module_index_q <= module_index_inc;
				end
			end
		end
	end

	// Contact image: all ones after reset and on enable, one bit updated per change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MAX_MODULES; m++) begin
				image_q[m] <= s88fb_pkg::IMAGE_RST;
			end
		end else if (enable_write) begin
			for (int m = 0; m < MAX_MODULES; m++) begin
				image_q[m] <= s88fb_pkg::IMAGE_RST;
			end
		end else if (accept && enable_q && changed) begin
			image_q[image_idx][bit_index_q] <= data_in;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded with every accepted tick.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (enable_q) begin
				out_lines_q      <= lines_next;
				change_valid_q   <= changed;
				change_address_q <= changed ? change_addr : '0;
				change_level_q   <= changed & data_in;
			end else begin
				out_lines_q      <= lines_q;
				change_valid_q   <= 1'b0;
				change_address_q <= '0;
				change_level_q   <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign load_level     = out_lines_q.load;
	assign clock_level    = out_lines_q.clock;
	assign reset_level    = out_lines_q.reset;
	assign change_valid   = change_valid_q;
	assign change_address = change_address_q;
	assign change_level   = change_level_q;

endmodule

`default_nettype wire

/* sv/s88fb_checker.sv */
// Port-level assertions for the feedback bus reader and their binding to it.
`default_nettype none

module s88fb_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_stall,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic                              load_level,
	input wire logic                              clock_level,
	input wire logic                              reset_level,
	input wire logic                              change_valid,
	input wire logic [s88fb_pkg::ADDR_W-1:0]      change_address,
	input wire logic                              change_level
);

	// A stalled result transaction stays and holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(change_address) &&
			$stable(change_valid) && $stable(change_level) && $stable(load_level))
		else $error("stalled result transaction changed");

	// The tick side is held back only while a result waits on a stalled output.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("tick stalled without a waiting result");

	// Without a change the address and level read as zero.
	a_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !change_valid |-> change_address == '0 && !change_level)
		else $error("change fields set without a change");

	// A change comes only from a read, which leaves the shift clock low.
	a_change_clock: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && change_valid |-> !clock_level)
		else $error("change reported with clock high");

	// The latch reset pulse falls inside the load window, with the clock low.
	a_reset_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reset_level |-> load_level && !clock_level)
		else $error("reset line high outside the load window");

endmodule

bind s88_feedback_bus_reader s88fb_checker u_s88fb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.load_level     (load_level),
	.clock_level    (clock_level),
	.reset_level    (reset_level),
	.change_valid   (change_valid),
	.change_address (change_address),
	.change_level   (change_level)
);

`default_nettype wire
